// ----- rtl/debounced_timed_power_switch_macros.svh -----
// Assertion helpers used by the top-level RTL module.
`ifndef DEBOUNCED_TIMED_POWER_SWITCH_MACROS_SVH
`define DEBOUNCED_TIMED_POWER_SWITCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtps same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtps next-cycle check failed");

`endif

// ----- rtl/dtps_pkg.sv -----
package dtps_pkg;

    localparam int W_TICK = 10;
    localparam int W_SEC  = 16;
    localparam int W_IDX  = 3;

    // Configuration register indexes
    localparam logic [W_IDX-1:0] CFG_TICKS_PER_SECOND  = 3'd0;
    localparam logic [W_IDX-1:0] CFG_DEBOUNCE_TICKS    = 3'd1;
    localparam logic [W_IDX-1:0] CFG_OFF_AFTER_SECONDS = 3'd2;
    localparam logic [W_IDX-1:0] CFG_CYCLE_SECONDS     = 3'd3;
    localparam logic [W_IDX-1:0] CFG_ON_SECONDS        = 3'd4;

    // Register reset values
    localparam logic [W_TICK-1:0] RST_TICKS_PER_SECOND  = 10'd1000;
    localparam logic [W_TICK-1:0] RST_DEBOUNCE_TICKS    = 10'd50;
    localparam logic [W_SEC-1:0]  RST_OFF_AFTER_SECONDS = 16'd21600;
    localparam logic [W_SEC-1:0]  RST_CYCLE_SECONDS     = 16'd223;
    localparam logic [W_SEC-1:0]  RST_ON_SECONDS        = 16'd60;

    localparam logic [W_TICK-1:0] TICK_MAX = '1;
    localparam logic [W_SEC-1:0]  SEC_MAX  = '1;

    typedef struct packed {
        logic button_pressed;
    } t_tick_item;

    typedef struct packed {
        logic load_on;
        logic led_on;
        logic press_seen;
    } t_result_item;

    typedef struct packed {
        logic [W_IDX-1:0] index;
        logic [W_SEC-1:0] value;
    } t_cfg_write;

endpackage

// ----- rtl/dtps_chan_if.sv -----
interface dtps_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/debounced_timed_power_switch.sv -----
// Channel   Dir  Payload                              Transfer
// i_tick    in   button_pressed                       valid & ready
// o_result  out  load_on, led_on, press_seen          valid & ready
// i_cfg     in   index (3b), value (16b)              valid & ready (ready tied high)
//
// One result per tick, written to the result register from the tick register.
// Sustains one tick transfer per clock: the tick register feeds the state
// update and result register in a single pass, so throughput is set only by
// the result register draining. Synchronous active-low reset clears control
// state but not the data registers, and loads the register defaults. A stalled
// result holds the tick register; state only advances when a result is written.
`include "debounced_timed_power_switch_macros.svh"

module debounced_timed_power_switch (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtps_chan_if.sink    i_tick,
    dtps_chan_if.source  o_result,
    dtps_chan_if.sink    i_cfg
);

    // Configuration registers
    logic [dtps_pkg::W_TICK-1:0] r_tps;
    logic [dtps_pkg::W_TICK-1:0] r_db_ticks;
    logic [dtps_pkg::W_SEC-1:0]  r_off_sec;
    logic [dtps_pkg::W_SEC-1:0]  r_cycle_sec;
    logic [dtps_pkg::W_SEC-1:0]  r_on_sec;

    // Input and result registers
    logic                   r_in_vld;
    logic                   r_in_level;
    logic                   r_out_vld;
    dtps_pkg::t_result_item r_out;
    dtps_pkg::t_result_item n_out;

    // Timer state
    logic [dtps_pkg::W_TICK-1:0] r_tick;
    logic [dtps_pkg::W_SEC-1:0]  r_elapsed;
    logic [dtps_pkg::W_SEC-1:0]  r_phase;
    logic                        r_led;
    logic                        r_load;
    logic [dtps_pkg::W_TICK-1:0] n_tick;
    logic [dtps_pkg::W_SEC-1:0]  n_elapsed;
    logic [dtps_pkg::W_SEC-1:0]  n_phase;
    logic                        n_led;
    logic                        n_load;

    logic advance;
    logic press;

    // ---------------- config port: always ready, out-of-range index dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= dtps_pkg::RST_TICKS_PER_SECOND;
            r_db_ticks  <= dtps_pkg::RST_DEBOUNCE_TICKS;
            r_off_sec   <= dtps_pkg::RST_OFF_AFTER_SECONDS;
            r_cycle_sec <= dtps_pkg::RST_CYCLE_SECONDS;
            r_on_sec    <= dtps_pkg::RST_ON_SECONDS;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                dtps_pkg::CFG_TICKS_PER_SECOND: begin
                    r_tps <= i_cfg.data.value[dtps_pkg::W_TICK-1:0];
                end
                dtps_pkg::CFG_DEBOUNCE_TICKS: begin
                    r_db_ticks <= i_cfg.data.value[dtps_pkg::W_TICK-1:0];
                end
                dtps_pkg::CFG_OFF_AFTER_SECONDS: begin
                    r_off_sec <= i_cfg.data.value;
                end
                dtps_pkg::CFG_CYCLE_SECONDS: begin
                    r_cycle_sec <= i_cfg.data.value;
                end
                dtps_pkg::CFG_ON_SECONDS: begin
                    r_on_sec <= i_cfg.data.value;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- handshake: tick register -> result register
    // A tick is processed when the result register is empty or draining.
    assign advance      = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_tick.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_tick.valid && i_tick.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_level <= i_tick.data.button_pressed;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    // ---------------- debounce
    dtps_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_level          (r_in_level),
        .i_debounce_ticks (r_db_ticks),
        .o_press          (press)
    );

    // ---------------- tick counter, second event, session timers
    always_comb begin
        logic [dtps_pkg::W_TICK-1:0] tick_inc;
        logic                        sec_evt;
        logic [dtps_pkg::W_SEC:0]    phase_inc;
        logic [dtps_pkg::W_SEC-1:0]  sec_elapsed;
        logic [dtps_pkg::W_SEC-1:0]  sec_phase;

        tick_inc  = r_tick + dtps_pkg::W_TICK'(1);
        // tps of zero or one fires every tick; a count left above tps fires next
        sec_evt   = (tick_inc >= r_tps) || (tick_inc == '0);
        phase_inc = {1'b0, r_phase} + (dtps_pkg::W_SEC + 1)'(1);

        sec_elapsed = r_elapsed;
        sec_phase   = r_phase;
        if (sec_evt) begin
            if (r_elapsed != dtps_pkg::SEC_MAX) begin
                sec_elapsed = r_elapsed + dtps_pkg::W_SEC'(1);
            end
            // wrap phase; cycle of zero acts as one
            if (phase_inc >= {1'b0, r_cycle_sec}) begin
                sec_phase = '0;
            end else begin
                sec_phase = phase_inc[dtps_pkg::W_SEC-1:0];
            end
        end

        n_tick    = sec_evt ? '0 : tick_inc;
        n_elapsed = sec_elapsed;
        n_phase   = sec_phase;
        n_led     = r_led;
        n_load    = r_load;

        if (press) begin
            n_elapsed = '0;
            n_phase   = '0;
            n_led     = 1'b1;
            n_load    = 1'b1;
        end else if (r_led && (sec_elapsed >= r_off_sec)) begin
            n_led  = 1'b0;
            n_load = 1'b0;
        end else if (r_led) begin
            n_load = (sec_phase < r_on_sec);
        end

        n_out.load_on    = n_load;
        n_out.led_on     = n_led;
        n_out.press_seen = press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_elapsed <= '0;
            r_phase   <= '0;
            r_led     <= 1'b0;
            r_load    <= 1'b0;
        end else if (advance) begin
            r_tick    <= n_tick;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_led     <= n_led;
            r_load    <= n_load;
        end
    end

    // ---------------- checks
    // load only runs inside an LED session
    `DTPS_ASSERT_NOW(a_load_needs_led, i_clk, i_rst_n, r_load, r_led)
    // a reported press starts a session with the load on
    `DTPS_ASSERT_NEXT(a_press_starts, i_clk, i_rst_n, advance && press,
        r_out_vld && r_out.led_on && r_out.load_on && r_out.press_seen)
    // timers hold while no tick is processed
    `DTPS_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !advance,
        $stable(r_tick) && $stable(r_elapsed) && $stable(r_phase))
    // a stalled result is not overwritten
    `DTPS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_out_vld && !o_result.ready, !advance)

endmodule

// ----- rtl/dtps_debounce.sv -----
// Button debouncer: a changed level must hold for debounce_ticks ticks.
module dtps_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_level,
    input  logic [dtps_pkg::W_TICK-1:0]   i_debounce_ticks,
    output logic                          o_press
);

    logic                        r_stable;
    logic                        r_active;
    logic [dtps_pkg::W_TICK-1:0] r_count;
    logic                        n_stable;
    logic                        n_active;
    logic [dtps_pkg::W_TICK-1:0] n_count;

    always_comb begin
        logic [dtps_pkg::W_TICK-1:0] cnt_inc;
        cnt_inc  = (r_count == dtps_pkg::TICK_MAX) ? r_count
                                                   : r_count + dtps_pkg::W_TICK'(1);
        n_stable = r_stable;
        n_active = r_active;
        n_count  = r_count;
        o_press  = 1'b0;
        if (i_step) begin
            if (i_level != r_stable) begin
                n_stable = i_level;
                n_count  = '0;
                n_active = 1'b1;
            end else if (r_active) begin
                n_count = cnt_inc;
                if (cnt_inc >= i_debounce_ticks) begin
                    n_active = 1'b0;
                    o_press  = r_stable;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_active <= 1'b0;
            r_count  <= '0;
        end else begin
            r_stable <= n_stable;
            r_active <= n_active;
            r_count  <= n_count;
        end
    end

endmodule

// ----- bench/dtps_checker.sv -----
module dtps_checker
    import dtps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_tick_valid,
    input  logic         i_tick_ready,
    input  t_tick_item   i_tick_data,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  t_result_item i_res_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  t_cfg_write   i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    // register shadow
    logic [W_TICK-1:0] cfg_tps;
    logic [W_TICK-1:0] cfg_deb;
    logic [W_SEC-1:0]  cfg_off;
    logic [W_SEC-1:0]  cfg_cycle;
    logic [W_SEC-1:0]  cfg_on;

    // switch state
    logic [W_TICK-1:0] tick_cnt;
    logic [W_TICK-1:0] bounce_cnt;
    logic              level_q;
    logic              bounce_busy;
    logic              led_q;
    logic              load_q;
    logic [W_SEC-1:0]  secs_since_press;
    logic [W_SEC-1:0]  phase;

    t_result_item expected_q[$];
    string        field_name[3] = '{"press_seen", "led_on", "load_on"};

    function automatic void count_second();
        if (secs_since_press != SEC_MAX)
            secs_since_press = secs_since_press + 1'b1;
        // cycle length zero acts as one
        if ({1'b0, phase} + 17'd1 >= {1'b0, cfg_cycle})
            phase = '0;
        else
            phase = phase + 1'b1;
    endfunction

    function automatic logic debounce_level(input logic level);
        if (level != level_q) begin
            level_q     = level;
            bounce_cnt  = '0;
            bounce_busy = 1'b1;
            return 1'b0;
        end
        if (!bounce_busy)
            return 1'b0;
        if (bounce_cnt != TICK_MAX)
            bounce_cnt = bounce_cnt + 1'b1;
        if (bounce_cnt >= cfg_deb) begin
            bounce_busy = 1'b0;
            return level_q;
        end
        return 1'b0;
    endfunction

    function automatic t_result_item step_switch(input logic level);
        logic         press;
        t_result_item r;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= cfg_tps || tick_cnt == '0) begin
            tick_cnt = '0;
            count_second();
        end
        press = debounce_level(level);
        if (press) begin
            secs_since_press = '0;
            phase            = '0;
            led_q            = 1'b1;
            load_q           = 1'b1;
        end else if (led_q && secs_since_press >= cfg_off) begin
            led_q  = 1'b0;
            load_q = 1'b0;
        end else if (led_q) begin
            load_q = (phase < cfg_on);
        end
        r.load_on    = load_q;
        r.led_on     = led_q;
        r.press_seen = press;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result_item want;
        bit           bad;
        if (!i_rst_n) begin
            cfg_tps          = RST_TICKS_PER_SECOND;
            cfg_deb          = RST_DEBOUNCE_TICKS;
            cfg_off          = RST_OFF_AFTER_SECONDS;
            cfg_cycle        = RST_CYCLE_SECONDS;
            cfg_on           = RST_ON_SECONDS;
            tick_cnt         = '0;
            bounce_cnt       = '0;
            level_q          = 1'b0;
            bounce_busy      = 1'b0;
            led_q            = 1'b0;
            load_q           = 1'b0;
            secs_since_press = '0;
            phase            = '0;
            expected_q.delete();
            o_fail_count     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_TICKS_PER_SECOND:  cfg_tps   = i_cfg_data.value[W_TICK-1:0];
                    CFG_DEBOUNCE_TICKS:    cfg_deb   = i_cfg_data.value[W_TICK-1:0];
                    CFG_OFF_AFTER_SECONDS: cfg_off   = i_cfg_data.value;
                    CFG_CYCLE_SECONDS:     cfg_cycle = i_cfg_data.value;
                    CFG_ON_SECONDS:        cfg_on    = i_cfg_data.value;
                    default: ;
                endcase
            end
            // a result trails its tick via the pipe, so check before push
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result load_on %0b led_on %0b press_seen %0b",
                             $time, i_res_data.load_on, i_res_data.led_on,
                             i_res_data.press_seen);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    bad  = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        if (i_res_data[i] !== want[i]) begin
                            $display("%0t: %s expected %0b actual %0b",
                                     $time, field_name[i], want[i], i_res_data[i]);
                            bad = 1'b1;
                        end
                    end
                    if (bad)
                        o_fail_count++;
                end
            end
            if (i_tick_valid && i_tick_ready)
                expected_q.push_back(step_switch(i_tick_data.button_pressed));
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- bench/tb_debounced_timed_power_switch.sv -----
module tb_debounced_timed_power_switch;
    import dtps_pkg::*;

    // Watchdog: far beyond the slowest legal run (every tick hit by a long
    // sender gap and a long result stall).
    localparam longint RUN_LIMIT = 64'd10_000_000;

    // Opening sequence, oldest level first: a clean press, a release with a
    // one-tick glitch in it, then a long hold so seconds and the load window
    // advance under the session.
    localparam logic [23:0] OPENING_LEVELS = 24'b0111_1010_0011_1111_1111_1111;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   fail_count;
    int   pending;
    bit   calm_tx;
    logic btn_level = 1'b0;

    // receiver stall state
    int   stall_left   = 0;
    int   stretch_left = 0;
    bit   calm_rx      = 1'b0;

    dtps_chan_if #(.T(t_tick_item))   tick_if ();
    dtps_chan_if #(.T(t_result_item)) result_if ();
    dtps_chan_if #(.T(t_cfg_write))   cfg_if ();

    debounced_timed_power_switch DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    dtps_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (tick_if.valid),
        .i_tick_ready (tick_if.ready),
        .i_tick_data  (tick_if.data),
        .i_res_valid  (result_if.valid),
        .i_res_ready  (result_if.ready),
        .i_res_data   (result_if.data),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_data   (cfg_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result sink: stretches of random stalls mix at random with stretches
    // where ready stays high, so stalls land on every phase of the pipe.
    always @(negedge i_clk) begin
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(50, 400);
            calm_rx      = ($urandom_range(0, 3) == 0);
        end else begin
            stretch_left--;
        end
        if (stall_left > 0)
            stall_left--;
        else if (!calm_rx)
            stall_left = pick_gap();
        result_if.ready <= (stall_left == 0);
    end

    // Called at a falling edge; returns at the falling edge after the
    // transfer with valid still high. The caller drops valid after a batch,
    // so valid is never lowered and raised in the same step.
    task automatic send_tick(input logic level);
        int gap;
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_if.valid               <= 1'b1;
        tick_if.data.button_pressed <= level;
        do @(posedge i_clk); while (!tick_if.ready);
        @(negedge i_clk);
    endtask

    // Writes all five registers back to back; valid drops after the last one.
    task automatic apply_setting(input logic [W_SEC-1:0] tps, input logic [W_SEC-1:0] deb,
                                 input logic [W_SEC-1:0] off, input logic [W_SEC-1:0] cyc,
                                 input logic [W_SEC-1:0] on_secs);
        t_cfg_write w[5];
        w[0] = '{index: CFG_TICKS_PER_SECOND,  value: tps};
        w[1] = '{index: CFG_DEBOUNCE_TICKS,    value: deb};
        w[2] = '{index: CFG_OFF_AFTER_SECONDS, value: off};
        w[3] = '{index: CFG_CYCLE_SECONDS,     value: cyc};
        w[4] = '{index: CFG_ON_SECONDS,        value: on_secs};
        for (int k = 0; k < 5; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= w[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the two-stage pipe empty out.
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Button traffic: mostly clean level changes held past the debounce
    // time (some held long enough for the session to time out), plus
    // bounces shorter than the debounce time and bursts of pure noise.
    task automatic random_ticks(input int n, input int deb);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                btn_level = !btn_level;
                len       = deb + $urandom_range(1, (r < 15) ? 300 : 25);
                repeat (len) send_tick(btn_level);
            end else if (r < 88) begin
                btn_level = !btn_level;
                len       = $urandom_range(1, (deb > 1) ? deb : 1);
                repeat (len) send_tick(btn_level);
            end else begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    btn_level = 1'($urandom_range(0, 1));
                    send_tick(btn_level);
                end
            end
            sent += len;
        end
        tick_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [W_SEC-1:0] tps, input logic [W_SEC-1:0] deb,
                             input logic [W_SEC-1:0] off, input logic [W_SEC-1:0] cyc,
                             input logic [W_SEC-1:0] on_secs, input int n);
        settle();
        apply_setting(tps, deb, off, cyc, on_secs);
        calm_tx = ($urandom_range(0, 3) == 0);
        random_ticks(n, int'(deb));
    endtask

    initial begin
        tick_if.valid   = 1'b0;
        tick_if.data    = '0;
        result_if.ready = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fast timing so the opening sequence sees presses, second events
        // and the load window turning over.
        apply_setting(3, 2, 5, 4, 2);
        calm_tx = 1'b0;
        for (int i = 23; i >= 0; i--)
            send_tick(OPENING_LEVELS[i]);
        tick_if.valid <= 1'b0;

        // tps debounce off_after cycle on items
        run_phase(3, 2, 5, 4, 2, 100);
        // all-zero registers: a second every tick, zero debounce, cycle of one
        run_phase(0, 0, 0, 0, 0, 100);
        run_phase(1, 1, 8, 3, 65535, 100);
        // session never times out, phase never wraps, load always in window
        run_phase(2, 3, 65535, 65535, 65535, 100);
        run_phase(7, 5, 40, 6, 3, 100);
        // widest tick registers: seconds are rare, debounce is very slow
        run_phase(1023, 1023, 1, 65535, 1, 1000);
        // back to the power-up values
        run_phase(W_SEC'(RST_TICKS_PER_SECOND), W_SEC'(RST_DEBOUNCE_TICKS),
                  RST_OFF_AFTER_SECONDS, RST_CYCLE_SECONDS, RST_ON_SECONDS, 100);
        run_phase(5, 4, 3, 2, 1, 100);
        settle();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dtps_pkg.sv
rtl/dtps_chan_if.sv
rtl/dtps_debounce.sv
rtl/debounced_timed_power_switch.sv
bench/dtps_checker.sv
bench/tb_debounced_timed_power_switch.sv
